// ===== sv/lens_distortion_remap_address_defines.svh =====
// assertion helpers shared by the remap address block
`ifndef LENS_DISTORTION_REMAP_ADDRESS_DEFINES_SVH
`define LENS_DISTORTION_REMAP_ADDRESS_DEFINES_SVH

// condition must hold in the same cycle
`define LDRA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lens remap check failed");

// condition must hold in the following cycle
`define LDRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lens remap check failed");

`endif

// ===== sv/ldra_pkg.sv =====
package ldra_pkg;

  // default output frame size
  localparam int OUT_WIDTH_DEF  = 938;
  localparam int OUT_HEIGHT_DEF = 606;

  // field widths
  localparam int ROW_W     = 10;
  localparam int COL_W     = 10;
  localparam int SRC_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int COEF_W    = 40;
  localparam int YSCALE_W  = 18;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K1         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K2         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_K3         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_K4         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = 3'd6;

  // register reset values
  localparam logic [SIZE_W-1:0]   RST_SRC_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0]   RST_SRC_HEIGHT = 13'd512;
  localparam logic [COEF_W-1:0]   RST_K1         = 40'd13354255;
  localparam logic [COEF_W-1:0]   RST_K2         = 40'd362016;
  localparam logic [COEF_W-1:0]   RST_K3         = 40'd18165786;
  localparam logic [COEF_W-1:0]   RST_K4         = 40'd283550060;
  localparam logic [YSCALE_W-1:0] RST_Y_SCALE    = 18'd64811;

  // scale quotient, Q24 with saturation just under 1024
  localparam int          DIV_BITS  = 34;
  localparam int          FRAC_BITS = 24;
  localparam logic [33:0] SMAX      = 34'h3_FFFF_FFFF;

  // per-pixel values carried down the pipe
  typedef struct packed {
    logic        xneg;
    logic        yneg;
    logic [11:0] xm;
    logic [28:0] ym;
  } side_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_row;
    logic [SRC_W-1:0] src_col;
    logic             in_range;
  } res_t;

  // 40 x 62 product as four 20 x 31 partials
  typedef struct packed {
    logic [50:0] p00;
    logic [50:0] p01;
    logic [50:0] p10;
    logic [50:0] p11;
  } pp_t;

  function automatic pp_t part_prod(input logic [39:0] mag, input logic [61:0] r);
    pp_t p;
    p.p00 = {31'b0, mag[19:0]} * {20'b0, r[30:0]};
    p.p01 = {31'b0, mag[19:0]} * {20'b0, r[61:31]};
    p.p10 = {31'b0, mag[39:20]} * {20'b0, r[30:0]};
    p.p11 = {31'b0, mag[39:20]} * {20'b0, r[61:31]};
    return p;
  endfunction

  // floor(mag * r / 2^40) from the partials
  function automatic logic [61:0] term_sum(input pp_t p);
    logic [101:0] acc;
    acc = {51'b0, p.p00} + {31'b0, p.p10, 20'b0} + {20'b0, p.p01, 31'b0} +
          {p.p11, 51'b0};
    return acc[101:40];
  endfunction

  function automatic logic signed [63:0] sterm(input logic neg, input logic [61:0] t);
    logic signed [63:0] v;
    v = $signed({2'b0, t});
    return neg ? -v : v;
  endfunction

endpackage

// ===== sv/ldra_ifs.sv =====
// pixel coordinate request channel
interface ldra_in_if;
  logic                        valid;
  logic                        ready;
  logic [ldra_pkg::ROW_W-1:0]  out_row;
  logic [ldra_pkg::COL_W-1:0]  out_col;
  modport source (output valid, out_row, out_col, input ready);
  modport sink (input valid, out_row, out_col, output ready);
endinterface

// source address result channel
interface ldra_out_if;
  logic                        valid;
  logic                        ready;
  logic [ldra_pkg::SRC_W-1:0]  src_row;
  logic [ldra_pkg::SRC_W-1:0]  src_col;
  logic                        in_range;
  modport source (output valid, src_row, src_col, in_range, input ready);
  modport sink (input valid, src_row, src_col, in_range, output ready);
endinterface

// register write channel
interface ldra_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ldra_pkg::CFG_IDX_W-1:0]  index;
  logic [ldra_pkg::COEF_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/lens_distortion_remap_address.sv =====
// Lens distortion remap address generator.
// pix_in carries one corrected output pixel (out_row, out_col) per transfer;
// pix_out returns the source pixel to fetch (src_row, src_col) and in_range,
// which is 0 with zero coordinates when the source point falls off the frame.
// cfg writes the frame size, the four rational coefficients and y_scale;
// it is always ready and should be used only while no pixel is in flight.
// Throughput: one pixel per cycle while pix_in.ready is high. The pipe has
// nine stages of squaring, partial products and sums, 35 stages of a radix-2
// divider (a saturation check, then one quotient bit per stage) and three
// stages of scaling and range check, followed by the output register.
// When pix_out stalls, the result goes to a skid register and the pipe
// freezes on the following cycle; pix_in.ready is low only while the skid
// register is full, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipe and restores the default
// registers: 640 x 512 source frame and the default coefficients.
`include "lens_distortion_remap_address_defines.svh"

module lens_distortion_remap_address #(
  parameter int OUT_WIDTH  = ldra_pkg::OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = ldra_pkg::OUT_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ldra_in_if.sink    pix_in,
  ldra_out_if.source pix_out,
  ldra_cfg_if.sink   cfg
);

  // configuration registers, coefficients kept as sign and magnitude
  logic [ldra_pkg::SIZE_W-1:0]   src_width;
  logic [ldra_pkg::SIZE_W-1:0]   src_height;
  logic [ldra_pkg::YSCALE_W-1:0] y_scale;
  logic [39:0]                   kmag [0:3];
  logic                          kneg [0:3];
  logic [39:0]                   cfg_neg;
  logic                          en;

  assign cfg.ready = 1'b1;
  assign cfg_neg   = -cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= ldra_pkg::RST_SRC_WIDTH;
      src_height <= ldra_pkg::RST_SRC_HEIGHT;
      y_scale    <= ldra_pkg::RST_Y_SCALE;
      kmag[0]    <= ldra_pkg::RST_K1;
      kmag[1]    <= ldra_pkg::RST_K2;
      kmag[2]    <= ldra_pkg::RST_K3;
      kmag[3]    <= ldra_pkg::RST_K4;
      kneg[0]    <= 1'b0;
      kneg[1]    <= 1'b0;
      kneg[2]    <= 1'b0;
      kneg[3]    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ldra_pkg::REG_SRC_WIDTH:  src_width <= cfg.data[ldra_pkg::SIZE_W-1:0];
        ldra_pkg::REG_SRC_HEIGHT: src_height <= cfg.data[ldra_pkg::SIZE_W-1:0];
        ldra_pkg::REG_K1: begin
          kneg[0] <= cfg.data[39];
          kmag[0] <= cfg.data[39] ? cfg_neg : cfg.data;
        end
        ldra_pkg::REG_K2: begin
          kneg[1] <= cfg.data[39];
          kmag[1] <= cfg.data[39] ? cfg_neg : cfg.data;
        end
        ldra_pkg::REG_K3: begin
          kneg[2] <= cfg.data[39];
          kmag[2] <= cfg.data[39] ? cfg_neg : cfg.data;
        end
        ldra_pkg::REG_K4: begin
          kneg[3] <= cfg.data[39];
          kmag[3] <= cfg.data[39] ? cfg_neg : cfg.data;
        end
        ldra_pkg::REG_Y_SCALE: y_scale <= cfg.data[ldra_pkg::YSCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: centred coordinates, vertical aspect
  logic signed [12:0] x_c, y_c;
  logic signed [31:0] yq_c;
  logic               v1;
  logic signed [12:0] x1;
  logic signed [31:0] yq1;

  assign x_c  = $signed({3'b0, pix_in.out_col}) - $signed(13'(OUT_WIDTH / 2));
  assign y_c  = $signed(13'(OUT_HEIGHT / 2)) - $signed({3'b0, pix_in.out_row});
  assign yq_c = 32'(y_c) * 32'($signed({1'b0, y_scale}));
  assign pix_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= pix_in.valid;
    if (en) begin
      x1  <= x_c;
      yq1 <= yq_c;
    end
  end

  // stage 2: magnitudes and squares
  logic signed [12:0] x_n;
  logic signed [31:0] yq_n;
  ldra_pkg::side_t    sd_c2, sd2;
  logic               v2;
  logic [22:0]        xsq2;
  logic [57:0]        ysq2;

  assign x_n  = -x1;
  assign yq_n = -yq1;
  always_comb begin
    sd_c2.xneg = x1[12];
    sd_c2.yneg = yq1[31];
    sd_c2.xm   = x1[12] ? x_n[11:0] : x1[11:0];
    sd_c2.ym   = yq1[31] ? yq_n[28:0] : yq1[28:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sd2  <= sd_c2;
      xsq2 <= 23'({12'b0, sd_c2.xm} * {12'b0, sd_c2.xm});
      ysq2 <= {29'b0, sd_c2.ym} * {29'b0, sd_c2.ym};
    end
  end

  // stage 3: squared radius, Q32
  ldra_pkg::side_t sd3;
  logic            v3;
  logic [59:0]     r2_3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      sd3  <= sd2;
      r2_3 <= {5'b0, xsq2, 32'b0} + {2'b0, ysq2};
    end
  end

  // stage 4: partials of r4 and of the r2 terms
  logic [43:0]     q16;
  ldra_pkg::side_t sd4;
  logic            v4;
  logic [43:0]     p00_4, p01_4, p11_4;
  ldra_pkg::pp_t   pk1_4, pk3_4;

  assign q16 = r2_3[59:16];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      sd4   <= sd3;
      p00_4 <= {22'b0, q16[21:0]} * {22'b0, q16[21:0]};
      p01_4 <= {22'b0, q16[21:0]} * {22'b0, q16[43:22]};
      p11_4 <= {22'b0, q16[43:22]} * {22'b0, q16[43:22]};
      pk1_4 <= ldra_pkg::part_prod(kmag[0], {2'b0, r2_3});
      pk3_4 <= ldra_pkg::part_prod(kmag[2], {2'b0, r2_3});
    end
  end

  // stage 5: r4 in Q8, r2 terms
  logic [87:0]     r4_full;
  ldra_pkg::side_t sd5;
  logic            v5;
  logic [61:0]     r4_5, t1_5, t3_5;

  assign r4_full = {p11_4, 44'b0} + {21'b0, p01_4, 23'b0} + {44'b0, p00_4};

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      sd5  <= sd4;
      r4_5 <= r4_full[85:24];
      t1_5 <= ldra_pkg::term_sum(pk1_4);
      t3_5 <= ldra_pkg::term_sum(pk3_4);
    end
  end

  // stage 6: partials of the r4 terms
  ldra_pkg::side_t sd6;
  logic            v6;
  logic [61:0]     t1_6, t3_6;
  ldra_pkg::pp_t   pk2_6, pk4_6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      sd6   <= sd5;
      t1_6  <= t1_5;
      t3_6  <= t3_5;
      pk2_6 <= ldra_pkg::part_prod(kmag[1], r4_5);
      pk4_6 <= ldra_pkg::part_prod(kmag[3], r4_5);
    end
  end

  // stage 7: r4 terms
  ldra_pkg::side_t sd7;
  logic            v7;
  logic [61:0]     t1_7, t2_7, t3_7, t4_7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      sd7  <= sd6;
      t1_7 <= t1_6;
      t3_7 <= t3_6;
      t2_7 <= ldra_pkg::term_sum(pk2_6);
      t4_7 <= ldra_pkg::term_sum(pk4_6);
    end
  end

  // stage 8: numerator and denominator, Q32
  ldra_pkg::side_t    sd8;
  logic               v8;
  logic signed [63:0] num8, den8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      sd8  <= sd7;
      num8 <= 64'sh1_0000_0000 + ldra_pkg::sterm(kneg[0], t1_7) +
              ldra_pkg::sterm(kneg[1], t2_7);
      den8 <= 64'sh1_0000_0000 + ldra_pkg::sterm(kneg[2], t3_7) +
              ldra_pkg::sterm(kneg[3], t4_7);
    end
  end

  // stage 9: magnitudes and quotient sign
  logic [63:0]     num_n, den_n;
  ldra_pkg::side_t sd9;
  logic            v9, sn9;
  logic [62:0]     nm9, dm9;

  assign num_n = -num8;
  assign den_n = -den8;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
    if (en) begin
      sd9 <= sd8;
      sn9 <= num8[63] ^ den8[63];
      nm9 <= num8[63] ? num_n[62:0] : num8[62:0];
      dm9 <= den8[63] ? den_n[62:0] : den8[62:0];
    end
  end

  // divider entry: saturation check, zero denominator included
  logic [72:0]     dv_r  [0:33];
  logic [62:0]     dv_d  [0:33];
  logic [33:0]     dv_q  [0:34];
  logic            dv_ovf[0:34];
  logic            dv_sn [0:34];
  logic            dv_v  [0:34];
  ldra_pkg::side_t dv_sd [0:34];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= v9;
    if (en) begin
      dv_sd[0]  <= sd9;
      dv_sn[0]  <= sn9;
      dv_ovf[0] <= {10'b0, nm9} >= {dm9, 10'b0};
      dv_r[0]   <= {10'b0, nm9};
      dv_d[0]   <= dm9;
      dv_q[0]   <= '0;
    end
  end

  // one quotient bit per stage, integer bits then fraction bits
  for (genvar i = 0; i < ldra_pkg::DIV_BITS; i++) begin : g_div
    localparam int B = ldra_pkg::DIV_BITS - 1 - i;
    logic [72:0] r_next;
    logic        bit_q;

    if (B >= ldra_pkg::FRAC_BITS) begin : g_int
      logic [72:0] cmp;
      assign cmp    = {10'b0, dv_d[i]} << (B - ldra_pkg::FRAC_BITS);
      assign bit_q  = dv_r[i] >= cmp;
      assign r_next = bit_q ? dv_r[i] - cmp : dv_r[i];
    end else begin : g_frac
      logic [72:0] rs;
      assign rs     = {dv_r[i][71:0], 1'b0};
      assign bit_q  = rs >= {10'b0, dv_d[i]};
      assign r_next = bit_q ? rs - {10'b0, dv_d[i]} : rs;
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[i+1] <= 1'b0;
      else if (en) dv_v[i+1] <= dv_v[i];
      if (en) begin
        dv_sd[i+1]  <= dv_sd[i];
        dv_sn[i+1]  <= dv_sn[i];
        dv_ovf[i+1] <= dv_ovf[i];
        dv_q[i+1]   <= {dv_q[i][32:0], bit_q};
      end
    end

    if (i < ldra_pkg::DIV_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[i+1] <= r_next;
          dv_d[i+1] <= dv_d[i];
        end
      end
    end
  end

  // scale products, y split over two partials
  logic [33:0] s_c;
  logic        vm, xneg_m, yneg_m, sn_m;
  logic [45:0] px_m, pyh_m, pyl_m;

  assign s_c = dv_ovf[34] ? ldra_pkg::SMAX : dv_q[34];

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= dv_v[34];
    if (en) begin
      xneg_m <= dv_sd[34].xneg;
      yneg_m <= dv_sd[34].yneg;
      sn_m   <= dv_sn[34];
      px_m   <= {34'b0, dv_sd[34].xm} * {12'b0, s_c};
      pyh_m  <= {17'b0, dv_sd[34].ym} * {29'b0, s_c[33:17]};
      pyl_m  <= {17'b0, dv_sd[34].ym} * {29'b0, s_c[16:0]};
    end
  end

  // round half away from zero, apply signs
  logic [45:0]        mx_sum;
  logic [63:0]        my_sum;
  logic signed [24:0] xa, ya;
  logic               vr;
  logic signed [24:0] xr, yr;

  assign mx_sum = px_m + 46'h80_0000;
  assign my_sum = {1'b0, pyh_m, 17'b0} + {18'b0, pyl_m} + 64'h80_0000_0000;
  assign xa     = $signed({3'b0, mx_sum[45:24]});
  assign ya     = $signed({1'b0, my_sum[63:40]});

  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else if (en) vr <= vm;
    if (en) begin
      xr <= (xneg_m ^ sn_m) ? -xa : xa;
      yr <= (yneg_m ^ sn_m) ? -ya : ya;
    end
  end

  // offset from source centre and frame check
  logic signed [26:0] ii, jj;
  logic               ok;
  logic               vf;
  ldra_pkg::res_t     res_c, resf;

  assign ii = $signed({15'b0, src_height[12:1]}) - $signed({{2{yr[24]}}, yr});
  assign jj = $signed({15'b0, src_width[12:1]}) + $signed({{2{xr[24]}}, xr});
  assign ok = !ii[26] && (ii[25:0] < {13'b0, src_height}) && (ii[25:0] <= 26'd4095) &&
              !jj[26] && (jj[25:0] < {13'b0, src_width}) && (jj[25:0] <= 26'd4095);

  always_comb begin
    res_c.src_row  = ok ? ii[11:0] : '0;
    res_c.src_col  = ok ? jj[11:0] : '0;
    res_c.in_range = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= vr;
    if (en) resf <= res_c;
  end

  // output register with skid; the pipe holds while the skid is full
  logic           out_v, skid_v, take;
  ldra_pkg::res_t out_r, skid_r;

  assign en   = !skid_v;
  assign take = !out_v || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (take) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= vf;
      end
    end else if (en && vf) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_r <= skid_v ? skid_r : resf;
    else if (en && vf) skid_r <= resf;
  end

  assign pix_out.valid    = out_v;
  assign pix_out.src_row  = out_r.src_row;
  assign pix_out.src_col  = out_r.src_col;
  assign pix_out.in_range = out_r.in_range;

  // checks
  `LDRA_ASSERT_NOW(a_black_zero, clk, rst, out_v && !out_r.in_range,
    out_r.src_row == '0 && out_r.src_col == '0)
  `LDRA_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_v, out_v)
  `LDRA_ASSERT_NOW(a_in_frame, clk, rst, out_v && out_r.in_range,
    {1'b0, out_r.src_row} < src_height && {1'b0, out_r.src_col} < src_width)
  `LDRA_ASSERT_NEXT(a_skid_holds, clk, rst, skid_v && !pix_out.ready, skid_v)

endmodule
